### rtl/core/asd_pkg.sv
// Shared constants, types and register codes for the accelerometer step detector.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

   // fixed-point format of the filter levels
   localparam int FRAC_BITS = 16;
   localparam int RATE_BITS = 16;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int CFG_W    = 16;
   localparam int SUMSQ_W  = 2 * SAMPLE_W;
   localparam int MAG_W    = SAMPLE_W;

   // level and product widths
   localparam int GRAV_W = MAG_W + FRAC_BITS + 1;
   localparam int BNC_W  = MAG_W + FRAC_BITS + 2;
   localparam int DIFF_W = BNC_W + 1;
   localparam int PROD_W = DIFF_W + RATE_BITS + 1;

   typedef logic signed [GRAV_W-1:0] grav_type;
   typedef logic signed [BNC_W-1:0]  bnc_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // square root sequencer: one result bit per step
   localparam int SQRT_STEPS = MAG_W;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
   localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(SQRT_STEPS - 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE_RATE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_STEP_INTERVAL = 3'd4;

   localparam logic [CFG_W-1:0] RST_BASELINE_RATE     = 16'd1311;
   localparam logic [CFG_W-1:0] RST_SMOOTHING_RATE    = 16'd19661;
   localparam logic [CFG_W-1:0] RST_HIGH_THRESHOLD    = 16'd1400;
   localparam logic [CFG_W-1:0] RST_LOW_THRESHOLD     = 16'd500;
   localparam logic [CFG_W-1:0] RST_MIN_STEP_INTERVAL = 16'd260;

   // gravity level after reset: 8192 in the integer part
   localparam int GRAVITY_START = 8192;
   localparam grav_type GRAV_RESET = grav_type'(GRAVITY_START) <<< FRAC_BITS;

   typedef struct packed {
      logic [CFG_W-1:0] baseline_rate;
      logic [CFG_W-1:0] smoothing_rate;
      logic [CFG_W-1:0] high_threshold;
      logic [CFG_W-1:0] low_threshold;
      logic [CFG_W-1:0] min_step_interval;
   } cfg_type;

   // one queued sample: sum of squares and its timestamp
   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [SUMSQ_W-1:0] sumsq;
   } work_type;

endpackage

`default_nettype wire

### rtl/core/asd_req_if.sv
// Request channel of the step detector: one three-axis sample with its timestamp.
// Depends on asd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface asd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [asd_pkg::SAMPLE_W-1:0] accel_x;
   logic signed [asd_pkg::SAMPLE_W-1:0] accel_y;
   logic signed [asd_pkg::SAMPLE_W-1:0] accel_z;
   logic [asd_pkg::TIME_W-1:0]          time_ms;

   modport source(output valid, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/asd_rsp_if.sv
// Response channel of the step detector: running step count and new-step flag.
// Depends on asd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface asd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [asd_pkg::COUNT_W-1:0] step_total;
   logic                        step_seen;

   modport source(output valid, step_total, step_seen, input ready);
   modport sink(input valid, step_total, step_seen, output ready);
endinterface

`default_nettype wire

### rtl/core/asd_csr_if.sv
// Register write channel of the step detector: register index and write data.
// Depends on asd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface asd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [asd_pkg::CSR_IDX_W-1:0] index;
   logic [asd_pkg::CFG_W-1:0]     data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/accel_step_detector.sv
// Top level of the accelerometer step detector: register file, front end, work
// queue and back end. Depends on asd_pkg, the channel interfaces and all asd_ modules.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one three-axis sample and a millisecond timestamp and
// yields exactly one response with the running step count and a flag for a
// newly counted step. The front end squares the axes into a register stage and
// hands the sum of squares to a two-entry queue, so it keeps taking requests
// while the back end works, as long as the queue has room. The back end takes a
// sample from the queue, computes the square root (one result bit per cycle in
// a digit unit), runs the two filter updates, which share one multiplier, and
// then decides the step and loads the response register. It takes a new sample
// only after it is through with the last, and a stalled response holds the
// back end in its last state. Registers are to be written through the csr_
// channel only while no sample is in flight; the block does not enforce this.
module accel_step_detector (
   input  wire logic  clock,
   input  wire logic  reset,
   asd_req_if.sink    req_bus,
   asd_rsp_if.source  rsp_bus,
   asd_csr_if.sink    csr_bus
);

   asd_pkg::cfg_type   cfg;
   logic               push_valid;
   logic               push_ready;
   asd_pkg::work_type  push_data;
   logic               work_valid;
   logic               work_ready;
   asd_pkg::work_type  work_data;

   // configuration registers
   asd_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // accept and square samples
   asd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple front from back
   asd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (work_valid),
      .pop_ready  (work_ready),
      .pop_data   (work_data)
   );

   // square root, filters and step decision
   asd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work_data  (work_data),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

### rtl/core/asd_regs.sv
// Configuration register file of the step detector.
// Depends on asd_pkg and asd_csr_if.
`timescale 1ns / 1ps
`default_nettype none

module asd_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   asd_csr_if.sink               csr_bus,
   output asd_pkg::cfg_type      cfg
);

   asd_pkg::cfg_type cfg_ff;
   asd_pkg::cfg_type cfg_in;

   // every write is taken at once
   assign csr_bus.ready = 1'b1;

   // decode the register index; unknown indexes leave the file unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            asd_pkg::REG_BASELINE_RATE:     cfg_in.baseline_rate     = csr_bus.data;
            asd_pkg::REG_SMOOTHING_RATE:    cfg_in.smoothing_rate    = csr_bus.data;
            asd_pkg::REG_HIGH_THRESHOLD:    cfg_in.high_threshold    = csr_bus.data;
            asd_pkg::REG_LOW_THRESHOLD:     cfg_in.low_threshold     = csr_bus.data;
            asd_pkg::REG_MIN_STEP_INTERVAL: cfg_in.min_step_interval = csr_bus.data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_rate     <= asd_pkg::RST_BASELINE_RATE;
         cfg_ff.smoothing_rate    <= asd_pkg::RST_SMOOTHING_RATE;
         cfg_ff.high_threshold    <= asd_pkg::RST_HIGH_THRESHOLD;
         cfg_ff.low_threshold     <= asd_pkg::RST_LOW_THRESHOLD;
         cfg_ff.min_step_interval <= asd_pkg::RST_MIN_STEP_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/asd_front.sv
// Front end of the step detector: accepts samples, squares the three axes and
// pushes sum of squares with timestamp into the work queue. Depends on asd_pkg, asd_req_if.
`timescale 1ns / 1ps
`default_nettype none

module asd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   asd_req_if.sink                   req_bus,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output asd_pkg::work_type         push_data
);

   logic                            hold_valid_ff;
   logic                            hold_valid_in;
   logic [asd_pkg::SUMSQ_W-1:0]     sq_x_ff;
   logic [asd_pkg::SUMSQ_W-1:0]     sq_y_ff;
   logic [asd_pkg::SUMSQ_W-1:0]     sq_z_ff;
   logic [asd_pkg::TIME_W-1:0]      time_ff;
   logic signed [asd_pkg::SUMSQ_W-1:0] sq_x;
   logic signed [asd_pkg::SUMSQ_W-1:0] sq_y;
   logic signed [asd_pkg::SUMSQ_W-1:0] sq_z;
   logic                            accept;

   // take a request whenever the stage is empty or draining this cycle
   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // square each axis; the largest square is 2^30, so 32 bits hold it
   assign sq_x = req_bus.accel_x * req_bus.accel_x;
   assign sq_y = req_bus.accel_y * req_bus.accel_y;
   assign sq_z = req_bus.accel_z * req_bus.accel_z;

   // hold the stage until the queue takes it
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_x_ff <= sq_x;
         sq_y_ff <= sq_y;
         sq_z_ff <= sq_z;
         time_ff <= req_bus.time_ms;
      end
   end

   // sum of three squares stays below 2^32
   assign push_valid        = hold_valid_ff;
   assign push_data.sumsq   = sq_x_ff + sq_y_ff + sq_z_ff;
   assign push_data.time_ms = time_ff;

endmodule

`default_nettype wire

### rtl/core/asd_queue.sv
// Short work queue between the front and back ends of the step detector.
// Depends on asd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   output logic                 push_ready,
   input  wire asd_pkg::work_type push_data,
   output logic                 pop_valid,
   input  wire logic            pop_ready,
   output asd_pkg::work_type    pop_data
);

   asd_pkg::work_type             slot_ff [asd_pkg::QUEUE_DEPTH];
   logic [asd_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [asd_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [asd_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [asd_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [asd_pkg::QCNT_W-1:0]    cnt_ff;
   logic [asd_pkg::QCNT_W-1:0]    cnt_in;
   logic                          push;
   logic                          pop;

   assign push_ready = (cnt_ff != asd_pkg::QCNT_W'(asd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == asd_pkg::QPTR_W'(asd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == asd_pkg::QPTR_W'(asd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill level never exceeds the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= asd_pkg::QCNT_W'(asd_pkg::QUEUE_DEPTH))
      else $error("work queue over-filled");

   // a push without a pop raises the fill level by one
   a_cnt_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("work queue lost a push");

   // the full queue refuses pushes
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == asd_pkg::QCNT_W'(asd_pkg::QUEUE_DEPTH)) |-> !push)
      else $error("push into full work queue");

endmodule

`default_nettype wire

### rtl/core/asd_back.sv
// Back end of the step detector: square root sequencer, two low-pass filters on a
// shared multiplier, step decision and response register. Depends on asd_pkg, asd_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module asd_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire asd_pkg::cfg_type cfg,
   input  wire logic            work_valid,
   output logic                 work_ready,
   input  wire asd_pkg::work_type work_data,
   asd_rsp_if.source            rsp_bus
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQRT = 3'd1;
   localparam logic [2:0] S_GMUL = 3'd2;
   localparam logic [2:0] S_GUPD = 3'd3;
   localparam logic [2:0] S_BMUL = 3'd4;
   localparam logic [2:0] S_BUPD = 3'd5;
   localparam logic [2:0] S_POST = 3'd6;

   logic [2:0]                        state_ff;
   logic [2:0]                        state_in;
   logic [asd_pkg::SQRT_CNT_W-1:0]    cnt_ff;
   logic [asd_pkg::SQRT_CNT_W-1:0]    cnt_in;
   logic [asd_pkg::SUMSQ_W-1:0]       val_ff;
   logic [asd_pkg::SUMSQ_W-1:0]       val_in;
   logic [asd_pkg::MAG_W+1:0]         rem_ff;
   logic [asd_pkg::MAG_W+1:0]         rem_in;
   logic [asd_pkg::MAG_W-1:0]         root_ff;
   logic [asd_pkg::MAG_W-1:0]         root_in;
   logic [asd_pkg::TIME_W-1:0]        time_ff;
   logic [asd_pkg::TIME_W-1:0]        time_in;
   asd_pkg::prod_type                 prod_ff;
   asd_pkg::prod_type                 prod_in;
   asd_pkg::grav_type                 grav_ff;
   asd_pkg::grav_type                 grav_in;
   asd_pkg::bnc_type                  bnc_ff;
   asd_pkg::bnc_type                  bnc_in;
   logic                              rearmed_ff;
   logic                              rearmed_in;
   logic [asd_pkg::TIME_W-1:0]        last_ff;
   logic [asd_pkg::TIME_W-1:0]        last_in;
   logic [asd_pkg::COUNT_W-1:0]       count_ff;
   logic [asd_pkg::COUNT_W-1:0]       count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [asd_pkg::COUNT_W-1:0]       total_ff;
   logic [asd_pkg::COUNT_W-1:0]       total_in;
   logic                              seen_ff;
   logic                              seen_in;

   logic [asd_pkg::MAG_W+1:0]         rem_shift;
   logic [asd_pkg::MAG_W+1:0]         trial;
   logic                              root_bit;
   asd_pkg::diff_type                 mag_lvl;
   asd_pkg::diff_type                 diff_g;
   asd_pkg::diff_type                 bnc_tgt;
   asd_pkg::diff_type                 diff_b;
   asd_pkg::diff_type                 mul_a;
   logic signed [asd_pkg::RATE_BITS:0] mul_b;
   asd_pkg::prod_type                 mul_p;
   asd_pkg::prod_type                 prod_shr;
   asd_pkg::bnc_type                  hi_lvl;
   asd_pkg::bnc_type                  lo_lvl;
   logic [asd_pkg::TIME_W-1:0]        elapsed;
   logic                              arm_now;
   logic                              hit;
   logic                              rsp_free;

   // one square root digit per step: bring down two bits, try root*4+1
   assign rem_shift = {rem_ff[asd_pkg::MAG_W-1:0], val_ff[asd_pkg::SUMSQ_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign root_bit  = (rem_shift >= trial);

   // filter operands; the magnitude enters with FRAC_BITS fraction bits
   assign mag_lvl = asd_pkg::diff_type'({root_ff, {asd_pkg::FRAC_BITS{1'b0}}});
   assign diff_g  = mag_lvl - asd_pkg::diff_type'(grav_ff);
   assign bnc_tgt = mag_lvl - asd_pkg::diff_type'(grav_ff);
   assign diff_b  = bnc_tgt - asd_pkg::diff_type'(bnc_ff);

   // shared multiplier: gravity step or bounce step
   assign mul_a = (state_ff == S_GMUL) ? diff_g : diff_b;
   assign mul_b = (state_ff == S_GMUL) ? $signed({1'b0, cfg.baseline_rate}) :
                                         $signed({1'b0, cfg.smoothing_rate});
   assign mul_p = mul_a * mul_b;

   // floor division by 2^RATE_BITS
   assign prod_shr = prod_ff >>> asd_pkg::RATE_BITS;

   // step decision on the registered bounce level
   assign hi_lvl  = asd_pkg::bnc_type'({cfg.high_threshold, {asd_pkg::FRAC_BITS{1'b0}}});
   assign lo_lvl  = asd_pkg::bnc_type'({cfg.low_threshold, {asd_pkg::FRAC_BITS{1'b0}}});
   assign elapsed = time_ff - last_ff;
   assign arm_now = rearmed_ff || (bnc_ff < lo_lvl);
   assign hit     = arm_now && (bnc_ff > hi_lvl) &&
                    (elapsed >= {{(asd_pkg::TIME_W - asd_pkg::CFG_W){1'b0}},
                                 cfg.min_step_interval});

   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign work_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      time_in      = time_ff;
      prod_in      = prod_ff;
      grav_in      = grav_ff;
      bnc_in       = bnc_ff;
      rearmed_in   = rearmed_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      total_in     = total_ff;
      seen_in      = seen_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               val_in   = work_data.sumsq;
               time_in  = work_data.time_ms;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in  = root_bit ? rem_shift - trial : rem_shift;
            root_in = {root_ff[asd_pkg::MAG_W-2:0], root_bit};
            val_in  = val_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == asd_pkg::SQRT_LAST) begin
               state_in = S_GMUL;
            end
         end
         S_GMUL: begin
            prod_in  = mul_p;
            state_in = S_GUPD;
         end
         S_GUPD: begin
            grav_in  = grav_ff + asd_pkg::grav_type'(prod_shr);
            state_in = S_BMUL;
         end
         S_BMUL: begin
            prod_in  = mul_p;
            state_in = S_BUPD;
         end
         S_BUPD: begin
            bnc_in   = bnc_ff + asd_pkg::bnc_type'(prod_shr);
            state_in = S_POST;
         end
         S_POST: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               seen_in      = hit;
               rearmed_in   = arm_now && !hit;
               if (hit) begin
                  count_in = count_ff + 1'b1;
                  last_in  = time_ff;
                  total_in = count_ff + 1'b1;
               end else begin
                  total_in = count_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grav_ff      <= asd_pkg::GRAV_RESET;
         bnc_ff       <= '0;
         rearmed_ff   <= 1'b1;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grav_ff      <= grav_in;
         bnc_ff       <= bnc_in;
         rearmed_ff   <= rearmed_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      val_ff   <= val_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      time_ff  <= time_in;
      prod_ff  <= prod_in;
      total_ff <= total_in;
      seen_ff  <= seen_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.step_total = total_ff;
   assign rsp_bus.step_seen  = seen_ff;

   // gravity tracks non-negative magnitudes and never goes below zero
   a_grav_nonneg: assert property (@(posedge clock) disable iff (reset)
      !grav_ff[asd_pkg::GRAV_W-1])
      else $error("gravity level went negative");

   // a posted result is presented on the next cycle
   a_post_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POST && rsp_free) |=> rsp_valid_ff)
      else $error("posted result not presented");

   // a counted step raises the count by exactly one and disarms
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POST && rsp_free && hit) |=>
         (count_ff == $past(count_ff) + 1'b1) && !rearmed_ff && seen_ff)
      else $error("step count out of step");

   // the filters start only after all square root digits are in
   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT && state_in == S_GMUL) |-> cnt_ff == asd_pkg::SQRT_LAST)
      else $error("square root left early");

endmodule

`default_nettype wire
